// ===== rtl/csim_pkg.sv =====
package csim_pkg;

    localparam int ELEMENT_WIDTH  = 16;
    localparam int SUM_WIDTH      = 48;
    localparam int PROD_WIDTH     = 2 * ELEMENT_WIDTH;
    localparam int ADD_WIDTH      = ((SUM_WIDTH > PROD_WIDTH) ? SUM_WIDTH : PROD_WIDTH) + 1;
    localparam int ROOT_WIDTH     = (SUM_WIDTH + 1) / 2;
    localparam int ROOT_STEPS     = ROOT_WIDTH;
    localparam int DEN_WIDTH      = 2 * ROOT_WIDTH;
    localparam int FRAC_BITS      = 14;
    localparam int Q_WIDTH        = FRAC_BITS + 1;
    localparam int SIM_WIDTH      = 16;
    localparam int CNT_MAX        = (ROOT_STEPS > FRAC_BITS) ? ROOT_STEPS : FRAC_BITS;
    localparam int CNT_WIDTH      = $clog2(CNT_MAX);
    localparam int IN_DATA_WIDTH  = ((2 * ELEMENT_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_WIDTH = ((SIM_WIDTH + 7) / 8) * 8;

    localparam logic [Q_WIDTH-1:0] Q_ONE = Q_WIDTH'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_MULT,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                 accept_en;
        logic                 root_load;
        logic                 root_step;
        logic                 mult;
        logic                 check;
        logic                 div_step;
        logic                 emit;
        logic [CNT_WIDTH-1:0] cnt;
    } ctrl_cmd_t;

    typedef struct packed {
        logic early_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/csim_ctrl.sv =====
module csim_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    input  csim_pkg::dp_status_t  status,
    output csim_pkg::ctrl_cmd_t   cmd
);

    csim_pkg::state_t                    state_reg;
    csim_pkg::state_t                    state_next;
    logic [csim_pkg::CNT_WIDTH-1:0]      cnt_reg;
    logic [csim_pkg::CNT_WIDTH-1:0]      cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csim_pkg::ST_RUN;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.cnt       = cnt_reg;
        unique case (state_reg)
            csim_pkg::ST_RUN:
            begin
                cmd.accept_en = 1'b1;
                if (in_valid && in_last)
                begin
                    state_next = csim_pkg::ST_DRAIN;
                end
            end
            csim_pkg::ST_DRAIN:
            begin
                state_next = csim_pkg::ST_ROOT_LOAD;
            end
            csim_pkg::ST_ROOT_LOAD:
            begin
                cmd.root_load = 1'b1;
                cnt_next      = csim_pkg::CNT_WIDTH'(csim_pkg::ROOT_STEPS - 1);
                state_next    = csim_pkg::ST_ROOT;
            end
            csim_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = csim_pkg::ST_MULT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            csim_pkg::ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = csim_pkg::ST_CHECK;
            end
            csim_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.early_done)
                begin
                    state_next = csim_pkg::ST_EMIT;
                end
                else
                begin
                    cnt_next   = csim_pkg::CNT_WIDTH'(csim_pkg::FRAC_BITS - 1);
                    state_next = csim_pkg::ST_DIV;
                end
            end
            csim_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = csim_pkg::ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            csim_pkg::ST_EMIT:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = csim_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = csim_pkg::ST_RUN;
            end
        endcase
    end

endmodule

// ===== rtl/csim_dp.sv =====
module csim_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  csim_pkg::ctrl_cmd_t                  cmd,
    input  logic                                 in_valid,
    input  logic [csim_pkg::IN_DATA_WIDTH-1:0]   in_data,
    output csim_pkg::dp_status_t                 status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [csim_pkg::OUT_DATA_WIDTH-1:0]  out_data,
    output logic                                 out_zero
);

    localparam int EW  = csim_pkg::ELEMENT_WIDTH;
    localparam int SW  = csim_pkg::SUM_WIDTH;
    localparam int PW  = csim_pkg::PROD_WIDTH;
    localparam int AW  = csim_pkg::ADD_WIDTH;
    localparam int RW  = csim_pkg::ROOT_WIDTH;
    localparam int DW  = csim_pkg::DEN_WIDTH;
    localparam int QW  = csim_pkg::Q_WIDTH;

    localparam logic [AW-1:0] SMAX_WIDE = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic [AW-1:0] SMIN_WIDE = {{(AW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic [AW-1:0] UMAX_WIDE = {{(AW-SW){1'b0}}, {SW{1'b1}}};

    typedef struct packed {
        logic [SW-1:0] rem;
        logic [SW-1:0] root;
    } root_pair_t;

    // one digit of the bit-by-bit floor square root
    function automatic root_pair_t root_iter(input logic [SW-1:0] rem,
                                             input logic [SW-1:0] root,
                                             input logic [SW-1:0] bitv);
        root_pair_t    res;
        logic [SW-1:0] trial;
        trial = root + bitv;
        if (rem >= trial)
        begin
            res.rem  = rem - trial;
            res.root = (root >> 1) + bitv;
        end
        else
        begin
            res.rem  = rem;
            res.root = root >> 1;
        end
        return res;
    endfunction

    logic signed [EW-1:0] elem_a;
    logic signed [EW-1:0] elem_b;
    logic signed [PW-1:0] prod_ab_next;
    logic signed [PW-1:0] sq_a_next;
    logic signed [PW-1:0] sq_b_next;

    logic signed [PW-1:0] prod_ab_reg;
    logic [PW-1:0]        sq_a_reg;
    logic [PW-1:0]        sq_b_reg;
    logic                 prod_valid_reg;

    logic [SW-1:0]        dot_sum_reg;
    logic [SW-1:0]        dot_sum_next;
    logic [SW-1:0]        sq_sum_a_reg;
    logic [SW-1:0]        sq_sum_a_next;
    logic [SW-1:0]        sq_sum_b_reg;
    logic [SW-1:0]        sq_sum_b_next;
    logic [AW-1:0]        dot_wide;
    logic [AW-1:0]        usum_a_wide;
    logic [AW-1:0]        usum_b_wide;

    logic [SW-1:0]        rem_a_reg;
    logic [SW-1:0]        rem_b_reg;
    logic [SW-1:0]        root_a_reg;
    logic [SW-1:0]        root_b_reg;
    logic [SW-1:0]        bit_val;
    root_pair_t           step_a;
    root_pair_t           step_b;

    logic [SW-1:0]        mag_reg;
    logic                 neg_reg;
    logic [DW-1:0]        den_reg;
    logic                 zero_reg;
    logic                 sat_hit;

    logic [DW-1:0]        div_r_reg;
    logic [DW:0]          two_r;
    logic [QW-1:0]        q_reg;
    logic [csim_pkg::SIM_WIDTH-1:0] q_ext;

    logic                 out_valid_reg;
    logic [csim_pkg::SIM_WIDTH-1:0] out_sim_reg;
    logic                 out_zero_reg;

    // product stage
    assign elem_a       = $signed(in_data[EW-1:0]);
    assign elem_b       = $signed(in_data[2*EW-1:EW]);
    assign prod_ab_next = elem_a * elem_b;
    assign sq_a_next    = elem_a * elem_a;
    assign sq_b_next    = elem_b * elem_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= cmd.accept_en && in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_ab_reg <= prod_ab_next;
        sq_a_reg    <= sq_a_next;
        sq_b_reg    <= sq_b_next;
    end

    // saturating accumulators
    assign dot_wide    = {{(AW-SW){dot_sum_reg[SW-1]}}, dot_sum_reg}
                       + {{(AW-PW){prod_ab_reg[PW-1]}}, prod_ab_reg};
    assign usum_a_wide = {{(AW-SW){1'b0}}, sq_sum_a_reg} + {{(AW-PW){1'b0}}, sq_a_reg};
    assign usum_b_wide = {{(AW-SW){1'b0}}, sq_sum_b_reg} + {{(AW-PW){1'b0}}, sq_b_reg};

    always_comb
    begin
        dot_sum_next  = dot_sum_reg;
        sq_sum_a_next = sq_sum_a_reg;
        sq_sum_b_next = sq_sum_b_reg;
        priority if (cmd.root_load)
        begin
            dot_sum_next  = '0;
            sq_sum_a_next = '0;
            sq_sum_b_next = '0;
        end
        else if (prod_valid_reg)
        begin
            if ($signed(dot_wide) > $signed(SMAX_WIDE))
            begin
                dot_sum_next = SMAX_WIDE[SW-1:0];
            end
            else if ($signed(dot_wide) < $signed(SMIN_WIDE))
            begin
                dot_sum_next = SMIN_WIDE[SW-1:0];
            end
            else
            begin
                dot_sum_next = dot_wide[SW-1:0];
            end
            sq_sum_a_next = (usum_a_wide > UMAX_WIDE) ? UMAX_WIDE[SW-1:0] : usum_a_wide[SW-1:0];
            sq_sum_b_next = (usum_b_wide > UMAX_WIDE) ? UMAX_WIDE[SW-1:0] : usum_b_wide[SW-1:0];
        end
        else
        begin
            dot_sum_next = dot_sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_sum_reg  <= '0;
            sq_sum_a_reg <= '0;
            sq_sum_b_reg <= '0;
        end
        else
        begin
            dot_sum_reg  <= dot_sum_next;
            sq_sum_a_reg <= sq_sum_a_next;
            sq_sum_b_reg <= sq_sum_b_next;
        end
    end

    // square roots, two digits of the radicand per cycle
    assign bit_val = SW'(1) << {cmd.cnt, 1'b0};
    assign step_a  = root_iter(rem_a_reg, root_a_reg, bit_val);
    assign step_b  = root_iter(rem_b_reg, root_b_reg, bit_val);

    // divide: one quotient bit per cycle
    assign two_r   = {div_r_reg, 1'b0};
    assign sat_hit = DW'(mag_reg) >= den_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.root_load)
        begin
            rem_a_reg  <= sq_sum_a_reg;
            rem_b_reg  <= sq_sum_b_reg;
            root_a_reg <= '0;
            root_b_reg <= '0;
            neg_reg    <= dot_sum_reg[SW-1];
            mag_reg    <= dot_sum_reg[SW-1] ? (SW'(0) - dot_sum_reg) : dot_sum_reg;
        end
        else if (cmd.root_step)
        begin
            rem_a_reg  <= step_a.rem;
            rem_b_reg  <= step_b.rem;
            root_a_reg <= step_a.root;
            root_b_reg <= step_b.root;
        end

        if (cmd.mult)
        begin
            den_reg  <= root_a_reg[RW-1:0] * root_b_reg[RW-1:0];
            zero_reg <= (root_a_reg == '0) || (root_b_reg == '0);
        end

        if (cmd.check)
        begin
            div_r_reg <= DW'(mag_reg);
            q_reg     <= (!zero_reg && sat_hit) ? csim_pkg::Q_ONE : '0;
        end
        else if (cmd.div_step)
        begin
            if (two_r >= {1'b0, den_reg})
            begin
                div_r_reg <= DW'(two_r - {1'b0, den_reg});
                q_reg     <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                div_r_reg <= two_r[DW-1:0];
                q_reg     <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign status.early_done = zero_reg || sat_hit;
    assign status.out_free   = !out_valid_reg || out_ready;

    // output register
    assign q_ext = {{(csim_pkg::SIM_WIDTH-QW){1'b0}}, q_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_sim_reg  <= neg_reg ? (csim_pkg::SIM_WIDTH'(0) - q_ext) : q_ext;
            out_zero_reg <= zero_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = csim_pkg::OUT_DATA_WIDTH'(out_sim_reg);
    assign out_zero  = out_zero_reg;

endmodule

// ===== rtl/cosine_similarity_engine_top.sv =====
// Streaming cosine similarity of two vectors. Each input word carries one element
// of each vector (signed Q8.8); the word with tlast set closes the vectors. The
// block keeps saturating sums of the products and of the squares, takes the floor
// square root of each square sum as that vector's norm, and returns one output word
// per vector pair: dot / (norm_a * norm_b) in signed Q1.14, truncated toward zero and
// saturated to +/-1.0. A zero norm sets the flag in tuser and gives similarity 0.
// Elements are taken one word per cycle. After the closing word the input stalls
// while the block folds in the last product, loads the root unit, runs the two-bit-per-
// step square-root loop, does the norm multiply and the range check, runs the
// one-bit-per-step divider and loads the output register. When a norm is zero or
// the ratio reaches one, the divider is skipped. The next vector pair may start
// while the previous result still waits to be taken; the block then holds only if
// that result is still pending when the next one is done.
module cosine_similarity_engine_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [csim_pkg::IN_DATA_WIDTH-1:0]   s_axis_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  logic                                 s_axis_tlast,   // last_element

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [csim_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata,   // [15:0] similarity
    output logic                                 m_axis_tuser    // [0] zero_norm
);

    csim_pkg::ctrl_cmd_t  cmd;
    csim_pkg::dp_status_t status;

    // sequencer: accumulate, root, multiply, divide, emit
    csim_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    // accumulators, root and divide units, output register
    csim_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_zero  (m_axis_tuser)
    );

    assign s_axis_tready = cmd.accept_en;

endmodule

// ===== test/cosine_similarity_monitor.sv =====
module cosine_similarity_monitor
    import csim_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,
    input  logic                      s_axis_tlast,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [OUT_DATA_WIDTH-1:0] m_axis_tdata,
    input  logic                      m_axis_tuser,
    output int                        mismatches,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [SIM_WIDTH-1:0] similarity;
        logic                        zero_norm;
    } cosine_result_t;

    localparam longint          DOT_MAX    = (64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1;
    localparam longint          DOT_MIN    = -DOT_MAX - 64'sd1;
    localparam longint unsigned ENERGY_MAX = (64'd1 << SUM_WIDTH) - 64'd1;

    longint          dot_acc;
    longint unsigned energy_a;
    longint unsigned energy_b;
    cosine_result_t  awaited_results[$];
    cosine_result_t  oldest;
    cosine_result_t  seen;

    // Build the root one bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = 31; k >= 0; k--)
        begin
            trial = root | (64'd1 << k);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint unsigned add_energy(input longint unsigned sum,
                                                   input longint unsigned sq);
        return (sq > ENERGY_MAX - sum) ? ENERGY_MAX : sum + sq;
    endfunction

    task automatic fold_pair(input logic signed [ELEMENT_WIDTH-1:0] a,
                             input logic signed [ELEMENT_WIDTH-1:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        if (prod > 0 && dot_acc > DOT_MAX - prod)
            dot_acc = DOT_MAX;
        else if (prod < 0 && dot_acc < DOT_MIN - prod)
            dot_acc = DOT_MIN;
        else
            dot_acc = dot_acc + prod;
        energy_a = add_energy(energy_a, longint'(longint'(a) * longint'(a)));
        energy_b = add_energy(energy_b, longint'(longint'(b) * longint'(b)));
    endtask

    function automatic cosine_result_t cosine_of_sums();
        longint unsigned norm_a;
        longint unsigned norm_b;
        longint unsigned span;
        longint unsigned mag;
        longint unsigned q;
        cosine_result_t  res;
        norm_a = floor_root(energy_a);
        norm_b = floor_root(energy_b);
        if (norm_a == 0 || norm_b == 0)
        begin
            res.similarity = '0;
            res.zero_norm  = 1'b1;
        end
        else
        begin
            span = norm_a * norm_b;
            mag  = (dot_acc < 0) ? longint'(-dot_acc) : longint'(dot_acc);
            q    = (mag >= span) ? (64'd1 << FRAC_BITS) : (mag << FRAC_BITS) / span;
            res.similarity = (dot_acc < 0) ? SIM_WIDTH'(-q) : SIM_WIDTH'(q);
            res.zero_norm  = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_acc  = 0;
            energy_a = 0;
            energy_b = 0;
            awaited_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.similarity = m_axis_tdata[SIM_WIDTH-1:0];
                seen.zero_norm  = m_axis_tuser;
                if (awaited_results.size() == 0)
                begin
                    $error("result word with none pending: similarity %0d, zero_norm %0b",
                           seen.similarity, seen.zero_norm);
                    mismatches++;
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (seen.similarity !== oldest.similarity)
                    begin
                        $error("similarity: expected %0d, actual %0d",
                               oldest.similarity, seen.similarity);
                        mismatches++;
                    end
                    if (seen.zero_norm !== oldest.zero_norm)
                    begin
                        $error("zero_norm: expected %0b, actual %0b",
                               oldest.zero_norm, seen.zero_norm);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                fold_pair(s_axis_tdata[ELEMENT_WIDTH-1:0],
                          s_axis_tdata[2*ELEMENT_WIDTH-1:ELEMENT_WIDTH]);
                if (s_axis_tlast)
                begin
                    awaited_results.push_back(cosine_of_sums());
                    dot_acc  = 0;
                    energy_a = 0;
                    energy_b = 0;
                end
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

// ===== test/cosine_similarity_engine_top_tb.sv =====
module cosine_similarity_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csim_pkg::*;

    logic                      clk;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_WIDTH-1:0]  s_axis_tdata  = '0;   // [15:0] elem_a, [31:16] elem_b
    logic                      s_axis_tlast  = 1'b0; // last_element
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;         // [15:0] similarity
    logic                      m_axis_tuser;         // [0] zero_norm

    int mismatches;
    int outstanding;
    int sent_words    = 0;
    bit drain_phase   = 1'b0;  // suppress all idling near the end

    cosine_similarity_engine_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cosine_similarity_monitor sim_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs; the slowest correct run is well under a tenth of this.
    initial
    begin
        #50ms;
        $display("cosine_similarity_engine_top test failed");
        $finish;
    end

    // Result side: stall in random bursts, never once the drain phase starts.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!drain_phase && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one element pair and hold it until the block takes the word.
    // An optional idle burst goes in front, so gaps land inside vectors as well as at ends.
    task automatic push_pair(input logic signed [ELEMENT_WIDTH-1:0] a,
                             input logic signed [ELEMENT_WIDTH-1:0] b,
                             input logic                         closing);
        int gap;
        if (!drain_phase && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= closing;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent_words++;
    endtask

    // Mix zeros, rail values, tiny values and full-range noise so every bit toggles.
    function automatic logic signed [ELEMENT_WIDTH-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3:    return 16'($urandom_range(0, 31)) - 16'sd16;
            default: return 16'($urandom());
        endcase
    endfunction

    // One vector pair of random length. Some shapes push the ratio toward +1, -1 or a zero norm.
    task automatic random_vector(input int len);
        logic signed [ELEMENT_WIDTH-1:0] a;
        logic signed [ELEMENT_WIDTH-1:0] b;
        int                              shape;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < len; i++)
        begin
            a = pick_element();
            case (shape)
                0:       b = a;
                1:       b = -a;
                2:
                begin
                    a = '0;
                    b = pick_element();
                end
                3:       b = a + 16'($urandom_range(0, 63)) - 16'sd32;
                default: b = pick_element();
            endcase
            push_pair(a, b, i == len - 1);
        end
    endtask

    initial
    begin
        int random_start;
        int len;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-pair and short vectors, rails, zero norms, floor-root overshoot, orthogonality.
        push_pair(16'sd1, 16'sd1, 1'b1);                 // ratio reaches one: saturate high
        push_pair(16'sh8000, 16'sh8000, 1'b1);           // both at negative rail
        push_pair(16'sh7FFF, 16'sh8000, 1'b1);           // opposite rails: saturate low
        push_pair(16'sd0, 16'sd5, 1'b1);                 // first vector zero
        push_pair(16'sd0, 16'sd0, 1'b1);                 // both zero
        push_pair(16'sd7, 16'sd0, 1'b1);                 // second vector zero
        push_pair(16'sd1, -16'sd1, 1'b0);                // floor roots overshoot, negative
        push_pair(16'sd1, -16'sd1, 1'b1);
        push_pair(16'sd256, 16'sd512, 1'b0);             // general mixed-sign case
        push_pair(16'sd512, -16'sd256, 1'b0);
        push_pair(-16'sd768, 16'sd100, 1'b1);
        push_pair(16'sd256, 16'sd0, 1'b0);               // orthogonal: zero, no flag
        push_pair(16'sd0, 16'sd256, 1'b1);
        push_pair(16'sh7FFF, -16'sd1, 1'b0);
        push_pair(16'sh8000, 16'sd300, 1'b0);
        push_pair(16'sd1, 16'sh7FFF, 1'b0);
        push_pair(-16'sd1, 16'sh8000, 1'b1);

        // Random vectors: mostly short, a few long; drop all idling for the last stretch.
        random_start = sent_words;
        while (sent_words - random_start < 500)
        begin
            if (sent_words - random_start >= 400)
                drain_phase = 1'b1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            random_vector(len);
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        // Wait out every pending result, then the root/divide latency once more.
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (60) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("cosine_similarity_engine_top test passed");
        else
            $display("cosine_similarity_engine_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/csim_pkg.sv
rtl/csim_ctrl.sv
rtl/csim_dp.sv
rtl/cosine_similarity_engine_top.sv
test/cosine_similarity_monitor.sv
test/cosine_similarity_engine_top_tb.sv
